// ===== design/zsc_pkg.sv =====
// Shared types and constants of the windowed z-score anomaly detector.
`default_nettype none
package zsc_pkg;
	localparam int RSSI_W = 8;
	localparam int LEN_W = 16;
	localparam int THR_W = 15;
	localparam int SCORE_W = 16;
	localparam int CNT_W = 32;
	localparam int IN_W = 24;
	localparam int OUT_W = 88;
	localparam int MIN_SAMPLES = 4;
	localparam logic [RSSI_W-1:0] RSSI_OFFSET = 8'h80;
	localparam logic [THR_W-1:0] THR_RESET = 15'd8192;
	localparam logic [SCORE_W-1:0] SCORE_MAX = 16'hFFFF;

	typedef struct packed {
		logic load;
		logic update;
		logic start;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic warm;
		logic busy;
		logic out_full;
	} status_t;
endpackage
`default_nettype wire

// ===== design/windowed_zscore_anomaly_detector_unit.sv =====
// Top level of the windowed z-score anomaly detector.
// While fewer than four samples are held, the result is formed without the statistic units;
// otherwise it waits for the 32-step long division and the 16-step square root
// that the two statistic units run side by side, unless neither statistic divides.
// One transaction at a time: a new one is accepted only once the last result is registered.
// Reset clears sums, counters and pointers and sets the threshold to 8192; the window needs no clearing.
`default_nettype none
module windowed_zscore_anomaly_detector_unit #(
	parameter int WINDOW_DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [zsc_pkg::IN_W-1:0]  s_tdata,   // rssi, frame_length
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [zsc_pkg::OUT_W-1:0]      m_tdata,   // anomaly_score, anomaly_flag,
	                                                  // warming_up, packets_seen, anomalies_seen
	input  wire logic                      cfg_we,
	input  wire logic [zsc_pkg::THR_W-1:0] cfg_wdata
);
	zsc_pkg::cmd_t    cmd;
	zsc_pkg::status_t status;

	zsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	zsc_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("input taken twice");
	a_warm_no_score: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[17] |-> m_tdata[16:0] == 17'd0) else $error("score while warming");
	a_flag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |-> m_tdata[15:0] != 16'd0) else $error("flag with zero score");
endmodule
`default_nettype wire

// ===== design/zsc_ram.sv =====
// Generic single-write, registered-read RAM.
`default_nettype none
module zsc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== design/zsc_stat.sv =====
// Iterative z-score unit: products, long division and integer square root.
`default_nettype none
module zsc_stat #(
	parameter int XW = 8,
	parameter int SW = 14,
	parameter int QW = 22,
	parameter int CW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [CW-1:0] n,
	input  wire logic [XW-1:0] x,
	input  wire logic [SW-1:0] s,
	input  wire logic [QW-1:0] q,
	output logic               busy,
	output logic [15:0]        k
);
	localparam int PW = CW + XW;
	localparam int DW = (PW > SW) ? PW : SW;
	localparam int VW = CW + QW;
	localparam int SSW = 2 * SW;
	localparam int MW = (VW > SSW) ? VW : SSW;
	localparam int DVW = VW + 7;
	localparam int HW = 2 * DW - 4;
	localparam int CPW = (HW > DVW) ? HW : DVW;

	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIF, ST_SQR, ST_DIVI, ST_DIV, ST_ROOT} st_t;

	st_t             state_q;
	logic [PW-1:0]   nx_q;
	logic [VW-1:0]   nq_q;
	logic [SSW-1:0]  ss_q;
	logic [DW-1:0]   dev_q;
	logic [VW-1:0]   var_q;
	logic            zero_q;
	logic [2*DW-1:0] nsq_q;
	logic [DVW-1:0]  dvs_q;
	logic [DVW-1:0]  rem_q;
	logic [31:0]     nlo_q;
	logic [31:0]     quo_q;
	logic [15:0]     k_q;
	logic [4:0]      cnt_q;

	logic [DW-1:0]   nx_ext;
	logic [DW-1:0]   s_ext;
	logic [HW-1:0]   high;
	logic [DVW:0]    tmp;
	logic [15:0]     trial;
	logic [31:0]     trial_sq;

	always_comb begin
		nx_ext = DW'(nx_q);
		s_ext = DW'(s);
		high = nsq_q[2*DW-1:4];
		tmp = {rem_q, nlo_q[31]};
		trial = k_q | (16'd1 << cnt_q[3:0]);
		trial_sq = trial * trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_DIF;
				ST_DIF: state_q <= ST_SQR;
				ST_SQR: state_q <= zero_q ? ST_IDLE : ST_DIVI;
				ST_DIVI: begin
					if (CPW'(high) >= CPW'(dvs_q)) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
						cnt_q <= 5'd31;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_ROOT;
						cnt_q <= 5'd15;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					k_q <= '0;
				end
			end
			ST_MUL: begin
				nx_q <= PW'(n * x);
				nq_q <= VW'(n * q);
				ss_q <= SSW'(s * s);
			end
			ST_DIF: begin
				dev_q <= (nx_ext >= s_ext) ? (nx_ext - s_ext) : (s_ext - nx_ext);
				zero_q <= MW'(nq_q) <= MW'(ss_q);
				var_q <= VW'(MW'(nq_q) - MW'(ss_q));
			end
			ST_SQR: begin
				nsq_q <= dev_q * dev_q;
				dvs_q <= DVW'({var_q, 6'b0}) + DVW'({var_q, 5'b0}) + DVW'({var_q, 2'b0});
			end
			ST_DIVI: begin
				if (CPW'(high) >= CPW'(dvs_q)) begin
					k_q <= zsc_pkg::SCORE_MAX;
				end
				rem_q <= DVW'(high);
				nlo_q <= {nsq_q[3:0], 28'b0};
				quo_q <= '0;
			end
			ST_DIV: begin
				nlo_q <= {nlo_q[30:0], 1'b0};
				if (tmp >= (DVW+1)'(dvs_q)) begin
					rem_q <= DVW'(tmp - (DVW+1)'(dvs_q));
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= tmp[DVW-1:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			ST_ROOT: begin
				if (trial_sq <= quo_q) begin
					k_q <= trial;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign k = k_q;
endmodule
`default_nettype wire

// ===== design/zsc_datapath.sv =====
// Datapath: window memory, running sums, two z-score units, counters and result register.
`default_nettype none
module zsc_datapath #(
	parameter int WINDOW_DEPTH = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire zsc_pkg::cmd_t               cmd,
	output zsc_pkg::status_t                 status,
	input  wire logic [zsc_pkg::IN_W-1:0]    s_tdata,
	input  wire logic                        cfg_we,
	input  wire logic [zsc_pkg::THR_W-1:0]   cfg_wdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [zsc_pkg::OUT_W-1:0]        m_tdata
);
	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int RW = zsc_pkg::RSSI_W;
	localparam int LW = zsc_pkg::LEN_W;
	localparam int RSW = RW + AW;
	localparam int RQW = 2 * RW + AW;
	localparam int LSW = LW + AW;
	localparam int LQW = 2 * LW + AW;

	logic [RW-1:0]                rssi_q;
	logic [LW-1:0]                len_q;
	logic [AW-1:0]                wp_q;
	logic [CW-1:0]                fill_q;
	logic [RSW-1:0]               rsum_q;
	logic [RQW-1:0]               rsq_q;
	logic [LSW-1:0]               lsum_q;
	logic [LQW-1:0]               lsq_q;
	logic [zsc_pkg::CNT_W-1:0]    pkt_q;
	logic [zsc_pkg::CNT_W-1:0]    anom_q;
	logic [zsc_pkg::THR_W-1:0]    thr_q;
	logic                         mvalid_q;
	logic [zsc_pkg::OUT_W-1:0]    mdata_q;

	logic [RW+LW-1:0]             rd_data;
	logic                         full;
	logic                         warm;
	logic [RW-1:0]                r_new;
	logic [RW-1:0]                r_old;
	logic [LW-1:0]                l_old;
	logic                         r_busy;
	logic                         l_busy;
	logic [15:0]                  r_k;
	logic [15:0]                  l_k;
	logic [zsc_pkg::SCORE_W-1:0]  score;
	logic                         flag;

	zsc_ram #(.WIDTH(RW + LW), .DEPTH(WINDOW_DEPTH)) u_window (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (wp_q),
		.wdata ({len_q, rssi_q}),
		.re    (cmd.load),
		.raddr (wp_q),
		.rdata (rd_data)
	);

	always_comb begin
		full = (fill_q == CW'(WINDOW_DEPTH));
		warm = (fill_q < CW'(zsc_pkg::MIN_SAMPLES));
		r_new = rssi_q ^ zsc_pkg::RSSI_OFFSET;
		r_old = full ? (rd_data[RW-1:0] ^ zsc_pkg::RSSI_OFFSET) : '0;
		l_old = full ? rd_data[RW+LW-1:RW] : '0;
		score = warm ? '0 : ((r_k > l_k) ? r_k : l_k);
		flag = !warm && (score > zsc_pkg::SCORE_W'(thr_q));
	end

	zsc_stat #(.XW(RW), .SW(RSW), .QW(RQW), .CW(CW)) u_rssi_stat (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.n      (fill_q),
		.x      (r_new),
		.s      (rsum_q),
		.q      (rsq_q),
		.busy   (r_busy),
		.k      (r_k)
	);

	zsc_stat #(.XW(LW), .SW(LSW), .QW(LQW), .CW(CW)) u_len_stat (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.n      (fill_q),
		.x      (len_q),
		.s      (lsum_q),
		.q      (lsq_q),
		.busy   (l_busy),
		.k      (l_k)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rssi_q <= s_tdata[RW-1:0];
			len_q <= s_tdata[RW+LW-1:RW];
		end
		if (cmd.finish) begin
			mdata_q <= {6'b0, anom_q + zsc_pkg::CNT_W'(flag), pkt_q, warm, flag, score};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			fill_q <= '0;
			rsum_q <= '0;
			rsq_q <= '0;
			lsum_q <= '0;
			lsq_q <= '0;
			pkt_q <= '0;
			anom_q <= '0;
			thr_q <= zsc_pkg::THR_RESET;
			mvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (cmd.update) begin
				rsum_q <= rsum_q - RSW'(r_old) + RSW'(r_new);
				rsq_q <= rsq_q - RQW'(r_old * r_old) + RQW'(r_new * r_new);
				lsum_q <= lsum_q - LSW'(l_old) + LSW'(len_q);
				lsq_q <= lsq_q - LQW'(l_old * l_old) + LQW'(len_q * len_q);
				wp_q <= (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + AW'(1);
				if (!full) begin
					fill_q <= fill_q + CW'(1);
				end
				pkt_q <= pkt_q + zsc_pkg::CNT_W'(1);
			end
			if (cmd.finish) begin
				anom_q <= anom_q + zsc_pkg::CNT_W'(flag);
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	assign status = '{warm: warm, busy: r_busy || l_busy, out_full: mvalid_q};
	assign m_tvalid = mvalid_q;
	assign m_tdata = mdata_q;
endmodule
`default_nettype wire

// ===== design/zsc_ctrl.sv =====
// Controller state machine sequencing load, update, scoring and result hand-off.
`default_nettype none
module zsc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic             m_tready,
	input  wire zsc_pkg::status_t status,
	output zsc_pkg::cmd_t         cmd
);
	typedef enum logic [2:0] {S_IDLE, S_UPD, S_RUN, S_WAIT, S_FIN} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free = !status.out_full || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: state_q <= S_RUN;
				S_RUN: state_q <= status.warm ? S_FIN : S_WAIT;
				S_WAIT: begin
					if (!status.busy) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		s_tready = (state_q == S_IDLE);
		cmd.load = s_tready && s_tvalid;
		cmd.update = (state_q == S_UPD);
		cmd.start = (state_q == S_RUN) && !status.warm;
		cmd.finish = (state_q == S_FIN) && out_free;
	end
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for the windowed z-score anomaly detector: queued stimulus, scoring and checking.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE = 64;

	typedef struct packed {
		logic [zsc_pkg::RSSI_W-1:0] rssi;
		logic [zsc_pkg::LEN_W-1:0] frame_length;
	} packet_t;

	typedef struct packed {
		logic [zsc_pkg::SCORE_W-1:0] anomaly_score;
		logic flagged;
		logic warming_up;
		logic [zsc_pkg::CNT_W-1:0] packets_seen;
		logic [zsc_pkg::CNT_W-1:0] anomalies_seen;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [zsc_pkg::IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [zsc_pkg::OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [zsc_pkg::THR_W-1:0] cfg_wdata = '0;

	packet_t packet_q[$];
	verdict_t verdict_q[$];
	int idle_mode = 0;
	int errors = 0;
	int quiet_cycles = 0;
	bit s_taken = 0;
	bit hold_req = 0;
	int hold_cnt = 0;

	logic [zsc_pkg::RSSI_W-1:0] win_rssi [DEPTH];
	logic [zsc_pkg::LEN_W-1:0] win_len [DEPTH];
	logic [5:0] wr_ptr = '0;
	logic [6:0] fill = '0;
	logic [13:0] rssi_acc = '0;
	logic [21:0] rssi_sq_acc = '0;
	logic [21:0] len_acc = '0;
	logic [37:0] len_sq_acc = '0;
	logic [zsc_pkg::CNT_W-1:0] packet_cnt = '0;
	logic [zsc_pkg::CNT_W-1:0] anomaly_cnt = '0;
	logic [zsc_pkg::THR_W-1:0] threshold = zsc_pkg::THR_RESET;

	windowed_zscore_anomaly_detector_unit #(.WINDOW_DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [15:0] z_score(input logic [127:0] n, input logic [127:0] x,
			input logic [127:0] s, input logic [127:0] q);
		logic [127:0] nx, dev, nq, ss, var_term, num, num_sq, t;
		logic [15:0] k;
		k = '0;
		nx = n * x;
		dev = (nx >= s) ? nx - s : s - nx;
		nq = n * q;
		ss = s * s;
		if (nq <= ss)
			return '0;
		var_term = nq - ss;
		num = dev << 14;
		num_sq = num * num;
		for (int b = 15; b >= 0; b--) begin
			t = 128'(k) | (128'd1 << b);
			if (128'd100 * t * t * var_term <= num_sq)
				k = t[15:0];
		end
		return k;
	endfunction

	function automatic verdict_t score_packet(input packet_t p);
		verdict_t v;
		logic [7:0] r, old_r;
		logic [15:0] zr, zl, sc;
		r = p.rssi + zsc_pkg::RSSI_OFFSET;
		if (fill >= DEPTH) begin
			old_r = win_rssi[wr_ptr] + zsc_pkg::RSSI_OFFSET;
			rssi_acc = rssi_acc - old_r;
			rssi_sq_acc = rssi_sq_acc - 22'(old_r) * 22'(old_r);
			len_acc = len_acc - win_len[wr_ptr];
			len_sq_acc = len_sq_acc - 38'(win_len[wr_ptr]) * 38'(win_len[wr_ptr]);
		end else begin
			fill = fill + 1'b1;
		end
		win_rssi[wr_ptr] = p.rssi;
		win_len[wr_ptr] = p.frame_length;
		rssi_acc = rssi_acc + r;
		rssi_sq_acc = rssi_sq_acc + 22'(r) * 22'(r);
		len_acc = len_acc + p.frame_length;
		len_sq_acc = len_sq_acc + 38'(p.frame_length) * 38'(p.frame_length);
		wr_ptr = wr_ptr + 1'b1;
		packet_cnt = packet_cnt + 1'b1;
		v = '0;
		v.warming_up = (fill < zsc_pkg::MIN_SAMPLES);
		if (!v.warming_up) begin
			zr = z_score(fill, r, rssi_acc, rssi_sq_acc);
			zl = z_score(fill, p.frame_length, len_acc, len_sq_acc);
			sc = (zr > zl) ? zr : zl;
			v.anomaly_score = sc;
			if (sc > threshold) begin
				v.flagged = 1'b1;
				anomaly_cnt = anomaly_cnt + 1'b1;
			end
		end
		v.packets_seen = packet_cnt;
		v.anomalies_seen = anomaly_cnt;
		return v;
	endfunction

	// driver
	always @(negedge clk) begin
		if (s_tvalid && !s_taken) begin
			s_tvalid <= 1'b1;
		end else if (packet_q.size() > 0 &&
				!((idle_mode == 1 && $urandom_range(99) < 76) ||
				(idle_mode == 3 && $urandom_range(99) < 37))) begin
			s_tvalid <= 1'b1;
			s_tdata <= {packet_q[0].frame_length, packet_q[0].rssi};
		end else begin
			s_tvalid <= 1'b0;
		end
		s_taken = 0;
	end

	// receiver
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else if ((idle_mode == 2 && $urandom_range(99) < 76) ||
				(idle_mode == 3 && $urandom_range(99) < 37)) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n) begin
			quiet_cycles++;
			if (s_tvalid && s_tready) begin
				verdict_q.push_back(score_packet(packet_q.pop_front()));
				s_taken = 1;
				quiet_cycles = 0;
			end
			if (m_tvalid && m_tready) begin
				quiet_cycles = 0;
				got = {m_tdata[15:0], m_tdata[16], m_tdata[17], m_tdata[49:18], m_tdata[81:50]};
				if (verdict_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result transaction %h", m_tdata);
				end else begin
					want = verdict_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch (exp/got): score %0d/%0d flag %b/%b",
								" warm %b/%b pkts %0d/%0d anom %0d/%0d"},
								want.anomaly_score, got.anomaly_score, want.flagged,
								got.flagged, want.warming_up, got.warming_up,
								want.packets_seen, got.packets_seen,
								want.anomalies_seen, got.anomalies_seen);
					end
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic drain();
		while (packet_q.size() > 0 || verdict_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [zsc_pkg::THR_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		threshold = value;
	endtask

	task automatic push(input logic [7:0] r, input logic [15:0] l);
		packet_t p;
		p.rssi = r;
		p.frame_length = l;
		packet_q.push_back(p);
	endtask

	task automatic random_phase(input int count);
		logic [7:0] base_r;
		logic [15:0] base_l;
		int kind;
		base_r = 8'($urandom);
		base_l = 16'($urandom);
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(9);
			if (kind < 7)
				push(base_r + 8'($urandom_range(6)) - 8'd3,
					base_l + 16'($urandom_range(200)) - 16'd100);
			else if (kind < 9)
				push(($urandom_range(1)) ? 8'h7F : 8'($urandom), 16'($urandom));
			else
				push(8'($urandom), ($urandom_range(1)) ? 16'hFFFF : 16'($urandom_range(3)));
			if ($urandom_range(49) == 0)
				base_l = 16'($urandom);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// warm-up, zero variance, then extreme outliers at the reset threshold
		for (int i = 0; i < 6; i++)
			push(8'h80, 16'd0);
		push(8'h7F, 16'hFFFF);
		push(8'h80, 16'd0);
		push(8'h7F, 16'd0);
		for (int i = 0; i < 6; i++)
			push(8'd5, 16'd1500);
		push(8'h80, 16'hFFFF);
		push(8'h7F, 16'd1500);
		push(8'hFF, 16'h8000);
		push(8'h00, 16'h0001);
		drain();

		write_threshold(15'd0);
		hold_req = 1;
		random_phase(250);
		drain();

		idle_mode = 1;
		write_threshold(15'd16384);
		random_phase(250);
		drain();

		idle_mode = 2;
		write_threshold(15'h7FFF);
		random_phase(250);
		drain();

		idle_mode = 3;
		write_threshold(15'($urandom_range(16384)));
		random_phase(250);
		drain();

		idle_mode = 0;
		write_threshold(15'd1000);
		random_phase(250);
		drain();

		idle_mode = 1;
		write_threshold(15'd3000);
		random_phase(125);
		idle_mode = 2;
		random_phase(125);
		drain();

		idle_mode = 3;
		write_threshold(15'd8192);
		random_phase(230);
		drain();

		if (errors == 0 && verdict_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
design/zsc_pkg.sv
design/zsc_ram.sv
design/zsc_stat.sv
design/zsc_datapath.sv
design/zsc_ctrl.sv
design/windowed_zscore_anomaly_detector_unit.sv
sim/testbench.sv
